>>> hdl/dwsp_pkg.sv
package dwsp_pkg;

  // wheel and lane counts
  localparam int WHEELS = 2;
  localparam int LANES  = 2;
  localparam int ACTIVE = (WHEELS < LANES) ? WHEELS : LANES;

  // field widths
  localparam int COUNT_W   = 32;
  localparam int TGT_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int DRIVE_W   = 32;
  localparam int REG_IDX_W = 3;

  // input tdata layout, lowest field first
  localparam int IN_W       = LANES * COUNT_W + 2 * LANES * TGT_W;
  localparam int TGT_BASE   = LANES * COUNT_W;
  localparam int OFS_BASE   = TGT_BASE + LANES * TGT_W;
  localparam int OUT_W      = LANES * DRIVE_W;

  // pipeline stages inside a lane
  localparam int NSTG = 7;

  // gain reset values
  localparam logic [GAIN_W-1:0] KP_RESET = 16'd1100;
  localparam logic [GAIN_W-1:0] KI_RESET = 16'd17;
  localparam logic [GAIN_W-1:0] KD_RESET = 16'd28;

  // integral step and output scale
  localparam logic signed [39:0] INTEG_STEP = 40'sd100;
  localparam longint unsigned SCALE_DIV = 64'd1000;

  // divide by the scale: clamp magnitude, then reciprocal multiply
  localparam int MAG_W       = 41;
  localparam int RECIP_W     = 42;
  localparam int RECIP_SHIFT = MAG_W + 10;
  localparam logic [MAG_W-1:0] MAG_LIM = MAG_W'(SCALE_DIV << 31);
  localparam logic [63:0] RECIP64 =
    ((64'd1 << RECIP_SHIFT) + SCALE_DIV - 64'd1) / SCALE_DIV;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP64);

  // configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_LEFT_PROP   = 3'd0,
    REG_LEFT_INTEG  = 3'd1,
    REG_LEFT_DERIV  = 3'd2,
    REG_RIGHT_PROP  = 3'd3,
    REG_RIGHT_INTEG = 3'd4,
    REG_RIGHT_DERIV = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } gain_t;

  // per stage load strobes, bit 0 is the first stage
  typedef struct packed {
    logic [NSTG-1:0] adv;
  } pipe_ctl_t;

  // scaled drive magnitude and sign from one lane
  typedef struct packed {
    logic        neg;
    logic [31:0] qmag;
  } lane_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sh007fffffff) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sh0080000000) begin
      r = -32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/dwsp_cfg.sv
module dwsp_cfg import dwsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [GAIN_W-1:0]    wr_data,
  output gain_t                gains [LANES]
);

  // gain registers, one set per wheel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < LANES; w++) begin
        gains[w].kp <= KP_RESET;
        gains[w].ki <= KI_RESET;
        gains[w].kd <= KD_RESET;
      end
    end else if (wr_en) begin
      case (wr_index)
        REG_LEFT_PROP:   gains[0].kp <= wr_data;
        REG_LEFT_INTEG:  gains[0].ki <= wr_data;
        REG_LEFT_DERIV:  gains[0].kd <= wr_data;
        REG_RIGHT_PROP:  gains[1].kp <= wr_data;
        REG_RIGHT_INTEG: gains[1].ki <= wr_data;
        REG_RIGHT_DERIV: gains[1].kd <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/dwsp_lane.sv
module dwsp_lane import dwsp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  pipe_ctl_t               ctl,
  input  gain_t                   gain,
  input  logic [COUNT_W-1:0]      count,
  input  logic signed [TGT_W-1:0] target,
  input  logic signed [TGT_W-1:0] offset,
  output lane_res_t               res
);

  // wheel state
  logic [COUNT_W-1:0]      prev_count;
  logic signed [TGT_W-1:0] prev_target;
  logic signed [31:0]      prev_error;
  logic signed [31:0]      error_sum;

  // stage registers
  logic signed [31:0] s1_err;
  logic               s1_clr;
  logic signed [31:0] s2_err;
  logic signed [31:0] s2_int;
  logic signed [32:0] s2_der;
  logic signed [48:0] s3_prop;
  logic signed [48:0] s3_int;
  logic signed [49:0] s3_der;
  logic signed [50:0] s4_total;
  logic [MAG_W-1:0]   s5_mag;
  logic               s5_neg;
  logic [41:0]        s6_ll;
  logic [41:0]        s6_lh;
  logic [40:0]        s6_hl;
  logic [40:0]        s6_hh;
  logic               s6_neg;

  // stage 1: speed from the count difference, error
  logic [COUNT_W-1:0]  diff;
  logic signed [39:0]  err_raw;
  logic                chg;

  assign diff    = count - prev_count;
  assign err_raw = 40'(target) + 40'(offset) - 40'($signed(diff));
  assign chg     = (target != prev_target);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_count  <= '0;
      prev_target <= '0;
    end else if (ctl.adv[0]) begin
      prev_count <= count;
      if (chg) begin
        prev_target <= target;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[0]) begin
      s1_err <= sat32(err_raw);
      s1_clr <= chg;
    end
  end

  // stage 2: integral and derivative, error history
  logic signed [39:0] e100;
  logic signed [39:0] isum_raw;
  logic signed [31:0] isum;
  logic signed [32:0] deriv;

  assign e100     = 40'(s1_err) * INTEG_STEP;
  assign isum_raw = 40'(error_sum) + e100;
  assign isum     = sat32(isum_raw);
  assign deriv    = 33'(s1_err) - 33'(prev_error);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_error <= '0;
      error_sum  <= '0;
    end else if (ctl.adv[1]) begin
      prev_error <= s1_clr ? 32'sd0 : s1_err;
      error_sum  <= s1_clr ? 32'sd0 : isum;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[1]) begin
      s2_err <= s1_err;
      s2_int <= isum;
      s2_der <= deriv;
    end
  end

  // stage 3: gain products
  logic signed [16:0] kp_s;
  logic signed [16:0] ki_s;
  logic signed [16:0] kd_s;
  logic signed [48:0] p_prop;
  logic signed [48:0] p_int;
  logic signed [49:0] p_der;

  assign kp_s   = $signed({1'b0, gain.kp});
  assign ki_s   = $signed({1'b0, gain.ki});
  assign kd_s   = $signed({1'b0, gain.kd});
  assign p_prop = kp_s * s2_err;
  assign p_int  = ki_s * s2_int;
  assign p_der  = kd_s * s2_der;

  always_ff @(posedge clk) begin
    if (ctl.adv[2]) begin
      s3_prop <= p_prop;
      s3_int  <= p_int;
      s3_der  <= p_der;
    end
  end

  // stage 4: sum of the three terms
  always_ff @(posedge clk) begin
    if (ctl.adv[3]) begin
      s4_total <= 51'(s3_prop) + 51'(s3_int) + 51'(s3_der);
    end
  end

  // stage 5: magnitude, clamped where the quotient saturates anyway
  logic [50:0] mag_full;

  assign mag_full = s4_total[50] ? 51'(-s4_total) : 51'(s4_total);

  always_ff @(posedge clk) begin
    if (ctl.adv[4]) begin
      s5_neg <= s4_total[50];
      s5_mag <= (mag_full >= 51'(MAG_LIM)) ? MAG_LIM : mag_full[MAG_W-1:0];
    end
  end

  // stage 6: partial products of magnitude times reciprocal
  logic [41:0] pp_ll;
  logic [41:0] pp_lh;
  logic [40:0] pp_hl;
  logic [40:0] pp_hh;

  assign pp_ll = s5_mag[20:0] * RECIP[20:0];
  assign pp_lh = s5_mag[20:0] * RECIP[41:21];
  assign pp_hl = s5_mag[40:21] * RECIP[20:0];
  assign pp_hh = s5_mag[40:21] * RECIP[41:21];

  always_ff @(posedge clk) begin
    if (ctl.adv[5]) begin
      s6_ll  <= pp_ll;
      s6_lh  <= pp_lh;
      s6_hl  <= pp_hl;
      s6_hh  <= pp_hh;
      s6_neg <= s5_neg;
    end
  end

  // stage 7: combine partials, quotient is the top bits
  logic [83:0] full;

  assign full = (84'(s6_hh) << 42) + ((84'(s6_lh) + 84'(s6_hl)) << 21) + 84'(s6_ll);

  always_ff @(posedge clk) begin
    if (ctl.adv[6]) begin
      res.neg  <= s6_neg;
      res.qmag <= full[RECIP_SHIFT+31:RECIP_SHIFT];
    end
  end

endmodule

>>> hdl/dwsp_merge.sv
module dwsp_merge import dwsp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lane_res_t        res [LANES],
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata
);

  logic [OUT_W-1:0] packed_drive;

  // apply sign and saturate each lane, pack into one word
  always_comb begin
    for (int w = 0; w < LANES; w++) begin
      if (res[w].neg) begin
        packed_drive[w*DRIVE_W +: DRIVE_W] = -res[w].qmag;
      end else if (res[w].qmag[31]) begin
        packed_drive[w*DRIVE_W +: DRIVE_W] = 32'h7fffffff;
      end else begin
        packed_drive[w*DRIVE_W +: DRIVE_W] = res[w].qmag;
      end
    end
  end

  assign in_ready = !m_tvalid || m_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      m_tdata <= packed_drive;
    end
  end

endmodule

>>> hdl/dual_wheel_speed_pid_unit.sv
// Two-wheel speed controller, one control tick per input transaction.
// Input channel s_*: one transaction carries both encoder counts, targets and
// offsets; each wheel runs in its own lane, and a merging stage packs both
// saturated drive values into one output transaction on m_*.
// Gains are written through wr_en / wr_index / wr_data, one 16-bit register per
// write; the user must write them only while no tick is in flight (not enforced).
// The accepting edge loads the first of 7 lane stages, and the output register
// follows the last one. Throughput: one tick per cycle while the receiver does
// not stall; each wheel's count, error and integral state is updated in the
// first two lane stages, so a following tick sees it without waiting.
// The divide by 1000 is a reciprocal multiply split into four partial
// products over two stages; the gain products take one stage.
// Reset clears the wheel state, loads the default gains and empties the
// pipeline. When the receiver stalls, stages fill up behind the output
// register and s_tready falls only once every stage holds a tick.
module dual_wheel_speed_pid_unit import dwsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // left_count, right_count, left_target, right_target, left_offset,
  // right_offset
  input  logic [IN_W-1:0]      s_tdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // left_drive, right_drive
  output logic [OUT_W-1:0]     m_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic                 wr_en,
  input  logic [REG_IDX_W-1:0] wr_index,
  input  logic [GAIN_W-1:0]    wr_data
);

  gain_t     gains [LANES];
  lane_res_t res   [LANES];
  pipe_ctl_t ctl;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] src;
  logic [NSTG:0]   rdy;
  logic            mrg_ready;

  // stage ready chain, a stage moves when it is empty or its successor moves
  always_comb begin
    src       = {vld[NSTG-2:0], s_tvalid};
    rdy[NSTG] = mrg_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
    ctl.adv = rdy[NSTG-1:0] & src;
  end

  assign s_tready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld[k] <= src[k];
        end
      end
    end
  end

  // gain registers
  dwsp_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .gains    (gains)
  );

  // one lane per wheel
  for (genvar w = 0; w < LANES; w++) begin : g_lane
    if (w < ACTIVE) begin : g_on
      dwsp_lane u_lane (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .gain   (gains[w]),
        .count  (s_tdata[w*COUNT_W +: COUNT_W]),
        .target ($signed(s_tdata[TGT_BASE + w*TGT_W +: TGT_W])),
        .offset ($signed(s_tdata[OFS_BASE + w*TGT_W +: TGT_W])),
        .res    (res[w])
      );
    end else begin : g_off
      assign res[w] = '0;
    end
  end

  // sign, saturation and output register
  dwsp_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vld[NSTG-1]),
    .in_ready (mrg_ready),
    .res      (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
